>>> rtl/core/lpcc_pkg.sv
// Shared types, constants and helper functions for the LED pixel color
// correction block. No dependencies.
package lpcc_pkg;

  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Divisors of the rounded gamma curves: round(n/d) = (2n + d) / (2d)
  localparam int unsigned CURVE_DEN  = 325125;
  localparam int unsigned SQUARE_DEN = 255;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pixel_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYPASS      = 3'd0,
    REG_CORR_GAINS  = 3'd1,
    REG_TEMP_GAINS  = 3'd2,
    REG_GAMMA_CODE  = 3'd3,
    REG_BRIGHTNESS  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GAMMA_IDENT,
    GAMMA_CURVE,
    GAMMA_SQUARE
  } gamma_mode_t;

  typedef struct packed {
    logic        bypass;
    logic [23:0] corr_gains;
    logic [23:0] temp_gains;
    gamma_mode_t gamma_mode;
    logic [7:0]  brightness;
  } cfg_t;

  typedef logic [255:0][7:0] lut_t;

  // floor(p / 255) for p <= 255*255, no divider needed
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

  // Gamma tables, built at elaboration
  function automatic lut_t gamma_lut_gen(input logic square);
    lut_t        lut;
    int unsigned v;
    int unsigned num;
    for (int i = 0; i < 256; i++) begin
      v = i;
      if (square) begin
        num = v * v;
        lut[i] = 8'((2 * num + SQUARE_DEN) / (2 * SQUARE_DEN));
      end else begin
        num = v * v * (1020 + v);
        lut[i] = 8'((2 * num + CURVE_DEN) / (2 * CURVE_DEN));
      end
    end
    return lut;
  endfunction

  localparam lut_t GAMMA_CURVE_LUT  = gamma_lut_gen(1'b0);
  localparam lut_t GAMMA_SQUARE_LUT = gamma_lut_gen(1'b1);

endpackage

>>> rtl/core/lpcc_cfg.sv
// Configuration register file with gamma mode decode.
// Depends on lpcc_pkg.
module lpcc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lpcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output lpcc_pkg::cfg_t                 cfg
);
  import lpcc_pkg::*;

  logic        bypass;
  logic [23:0] corr_gains;
  logic [23:0] temp_gains;
  logic [7:0]  gamma_code;
  logic [7:0]  brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass     <= 1'b0;
      corr_gains <= 24'hFF_FFFF;
      temp_gains <= 24'hFF_FFFF;
      gamma_code <= 8'd100;
      brightness <= 8'd255;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_BYPASS:     bypass     <= cfg_data[0];
        REG_CORR_GAINS: corr_gains <= cfg_data[23:0];
        REG_TEMP_GAINS: temp_gains <= cfg_data[23:0];
        REG_GAMMA_CODE: gamma_code <= cfg_data[7:0];
        REG_BRIGHTNESS: brightness <= cfg_data[7:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_comb begin
    cfg.bypass     = bypass;
    cfg.corr_gains = corr_gains;
    cfg.temp_gains = temp_gains;
    cfg.brightness = brightness;
    if (gamma_code <= 8'd100)
      cfg.gamma_mode = GAMMA_IDENT;
    else if (gamma_code >= 8'd200 && gamma_code <= 8'd240)
      cfg.gamma_mode = GAMMA_CURVE;
    else
      cfg.gamma_mode = GAMMA_SQUARE;
  end

endmodule

>>> rtl/core/lpcc_ctrl.sv
// Valid tracking and per-stage load enables for the five-stage pipeline.
// Depends on lpcc_pkg.
module lpcc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpcc_pkg::NUM_STAGES-1:0] en
);
  import lpcc_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--)
      rdy[i] = !vld[i] || rdy[i+1];
    en = rdy[NUM_STAGES-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0])
        vld[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i])
          vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NUM_STAGES-1];

  // requests in flight change only by what enters and leaves
  a_count: assert property (@(posedge clk) disable iff (rst)
    ##1 !$past(rst) |-> $countones(vld) == $past($countones(vld))
        + $past(in_valid && in_ready) - $past(out_valid && out_ready))
    else $error("pipeline request count mismatch");

  // a held stage keeps its request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ##1 !$past(rst) |-> ($past(vld & ~en) & ~vld) == '0)
    else $error("stalled stage lost its request");

  // any bubble lets a new request in
  a_bubble: assert property (@(posedge clk) disable iff (rst)
    (vld != '1) |-> in_ready)
    else $error("input blocked with a free stage");

endmodule

>>> rtl/core/lpcc_chan.sv
// Datapath for one color channel: gain, temperature, gamma, brightness.
// Depends on lpcc_pkg.
module lpcc_chan (
  input  logic                            clk,
  input  logic [lpcc_pkg::NUM_STAGES-1:0] en,
  input  logic [7:0]                      pix,
  input  logic [7:0]                      corr_gain,
  input  logic [7:0]                      temp_gain,
  input  lpcc_pkg::gamma_mode_t           gamma_mode,
  input  logic [7:0]                      brightness,
  input  logic                            bypass,
  output logic [7:0]                      result
);
  import lpcc_pkg::*;

  logic [7:0]  raw [NUM_STAGES-1];
  logic [15:0] prod0;
  logic [15:0] prod1;
  logic [7:0]  gam;
  logic [15:0] prod3;
  logic [7:0]  temp_v;
  logic [7:0]  gam_next;

  always_comb begin
    temp_v = div255(prod1);
    unique case (gamma_mode)
      GAMMA_IDENT:  gam_next = temp_v;
      GAMMA_CURVE:  gam_next = GAMMA_CURVE_LUT[temp_v];
      GAMMA_SQUARE: gam_next = GAMMA_SQUARE_LUT[temp_v];
      default:      gam_next = temp_v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod0  <= pix * corr_gain;
      raw[0] <= pix;
    end
    if (en[1]) begin
      prod1  <= div255(prod0) * temp_gain;
      raw[1] <= raw[0];
    end
    if (en[2]) begin
      gam    <= gam_next;
      raw[2] <= raw[1];
    end
    if (en[3]) begin
      prod3  <= gam * brightness;
      raw[3] <= raw[2];
    end
    if (en[4])
      result <= bypass ? raw[3] : div255(prod3);
  end

endmodule

>>> rtl/core/led_pixel_color_correction.sv
// LED pixel color correction, top level.
// Depends on lpcc_pkg, lpcc_cfg, lpcc_ctrl, lpcc_chan.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data) takes one RGB pixel per
//    request; output channel (out_valid/out_ready/out_data) gives the
//    corrected pixel. Both use valid/ready, transfer when both are high.
//  - Each channel: scale by correction gain, scale by temperature gain,
//    gamma (identity, 2.2 curve or square), scale by brightness.
//    scale is floor(v*s/255). Bypass passes the pixel through unchanged.
//  - Path: an accepted pixel moves through the stage registers in turn,
//    held by a stall; out_valid is high while the last stage holds it.
//  - Throughput: one pixel per clock when not stalled, through the five
//    register stages (two products, gamma table, brightness, output).
//  - Stall: each stage holds its pixel while the next is full and stuck;
//    in_ready drops only when all five stages hold a pixel and out_ready
//    is low. Bubbles close up, nothing is dropped or repeated.
//  - Reset (rst, synchronous): pipeline empties, registers return to
//    bypass=0, gains 0xFFFFFF, gamma code 100, brightness=255.
//  - Config: cfg_wr_en/cfg_index/cfg_data, registered with no
//    read-back; write only while the pipeline is empty. Unmapped
//    indexes are ignored.
module led_pixel_color_correction (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lpcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lpcc_pkg::pixel_in_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lpcc_pkg::pixel_out_t           out_data
);
  import lpcc_pkg::*;

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] en;

  lpcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // shared stage enables keep all three channels in lockstep
  lpcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  // gains are packed red in the top byte, blue in the low byte
  lpcc_chan u_red (
    .clk        (clk),
    .en         (en),
    .pix        (in_data.red_in),
    .corr_gain  (cfg.corr_gains[23:16]),
    .temp_gain  (cfg.temp_gains[23:16]),
    .gamma_mode (cfg.gamma_mode),
    .brightness (cfg.brightness),
    .bypass     (cfg.bypass),
    .result     (out_data.red_out)
  );

  lpcc_chan u_green (
    .clk        (clk),
    .en         (en),
    .pix        (in_data.green_in),
    .corr_gain  (cfg.corr_gains[15:8]),
    .temp_gain  (cfg.temp_gains[15:8]),
    .gamma_mode (cfg.gamma_mode),
    .brightness (cfg.brightness),
    .bypass     (cfg.bypass),
    .result     (out_data.green_out)
  );

  lpcc_chan u_blue (
    .clk        (clk),
    .en         (en),
    .pix        (in_data.blue_in),
    .corr_gain  (cfg.corr_gains[7:0]),
    .temp_gain  (cfg.temp_gains[7:0]),
    .gamma_mode (cfg.gamma_mode),
    .brightness (cfg.brightness),
    .bypass     (cfg.bypass),
    .result     (out_data.blue_out)
  );

endmodule
